[src/sparse_matrix_vector_multiply_unit_defines.svh]
// Assertion macros used by the sparse matrix vector multiply top level.
`ifndef SPARSE_MATRIX_VECTOR_MULTIPLY_UNIT_DEFINES_SVH
`define SPARSE_MATRIX_VECTOR_MULTIPLY_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[src/smvm_pkg.sv]
// Types and constants of the sparse matrix vector multiply unit.
package smvm_pkg;

   localparam int MaxLen    = 4096;
   localparam int IdxW      = 12;
   localparam int ValW      = 32;
   localparam int SumW      = 64;
   localparam int CntW      = 13;
   localparam int AddrWideW = 17;
   localparam int CsrIdxW   = 2;

   localparam logic [CntW-1:0] RowEndReset = 13'h1000;

   typedef enum logic [1:0] {
      MODE_LOAD    = 2'd0,
      MODE_NONZERO = 2'd1,
      MODE_EMPTY   = 2'd2
   } mode_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_ROW_BEGIN = 2'd0,
      CSR_ROW_END   = 2'd1
   } csr_index_type;

   // Control travelling with a nonzero or empty-row word down the pipeline.
   typedef struct packed {
      logic valid;
      logic nonzero;
      logic done;
      logic in_range;
   } stage_ctl_type;

   typedef struct packed {
      logic               valid;
      logic [CsrIdxW-1:0] index;
      logic [CntW-1:0]    data;
   } csr_write_type;

   typedef struct packed {
      logic            valid;
      logic [IdxW-1:0] index;
      logic [SumW-1:0] sum;
      logic            last;
      logic            close_pending;
   } rsp_word_type;

endpackage

[src/smvm_vec_mem.sv]
// Vector element memory: one write port, one registered read port.
module smvm_vec_mem #(
   parameter int DEPTH  = smvm_pkg::MaxLen,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [ADDR_W-1:0]          wr_addr,
   input  logic [smvm_pkg::ValW-1:0]  wr_data,
   input  logic                       rd_en,
   input  logic [ADDR_W-1:0]          rd_addr,
   output logic [smvm_pkg::ValW-1:0]  rd_data
);

   logic [smvm_pkg::ValW-1:0] mem [DEPTH];
   logic [smvm_pkg::ValW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // The read word holds while the pipeline is stalled.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/smvm_row_acc.sv]
// Product register, saturating row accumulator, row counter and result register.
module smvm_row_acc (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  smvm_pkg::stage_ctl_type       a_ctl,
   input  logic signed [smvm_pkg::ValW-1:0] a_value,
   input  logic signed [smvm_pkg::ValW-1:0] elem,
   input  smvm_pkg::csr_write_type       csr_write,
   output smvm_pkg::rsp_word_type        rsp_word
);

   localparam logic [smvm_pkg::SumW-1:0] SumMax = {1'b0, {(smvm_pkg::SumW-1){1'b1}}};
   localparam logic [smvm_pkg::SumW-1:0] SumMin = {1'b1, {(smvm_pkg::SumW-1){1'b0}}};

   smvm_pkg::stage_ctl_type b_ctl_ff;
   logic signed [smvm_pkg::SumW-1:0] prod_ff;
   logic signed [smvm_pkg::SumW-1:0] prod_in;
   logic signed [smvm_pkg::SumW-1:0] prod_full;

   logic [smvm_pkg::SumW-1:0] acc_ff, acc_in;
   logic [smvm_pkg::CntW-1:0] cnt_ff, cnt_in;
   logic [smvm_pkg::IdxW-1:0] row_begin_ff, row_begin_in;
   logic [smvm_pkg::CntW-1:0] row_end_ff, row_end_in;

   logic                      out_valid_ff, out_valid_in;
   logic [smvm_pkg::IdxW-1:0] out_index_ff, out_index_in;
   logic [smvm_pkg::SumW-1:0] out_sum_ff, out_sum_in;
   logic                      out_last_ff, out_last_in;

   logic [smvm_pkg::SumW-1:0] sum_raw, sum_sat;
   logic [smvm_pkg::CntW-1:0] cnt_next;
   logic                      overflow, close, is_last;

   // Both operands are signed, so the product is formed at the full 64 bits.
   assign prod_full = a_value * elem;
   assign prod_in   = a_ctl.in_range ? prod_full : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ctl_ff <= '0;
      end else if (advance) begin
         b_ctl_ff <= a_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
      end
   end

   always_comb begin
      sum_raw  = acc_ff + prod_ff;
      overflow = (acc_ff[smvm_pkg::SumW-1] == prod_ff[smvm_pkg::SumW-1]) &&
                 (sum_raw[smvm_pkg::SumW-1] != acc_ff[smvm_pkg::SumW-1]);
      sum_sat  = overflow ? (acc_ff[smvm_pkg::SumW-1] ? SumMin : SumMax) : sum_raw;

      cnt_next = cnt_ff + 1'b1;
      is_last  = (cnt_next == row_end_ff);
      close    = b_ctl_ff.valid && (!b_ctl_ff.nonzero || b_ctl_ff.done);

      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      row_begin_in = row_begin_ff;
      row_end_in   = row_end_ff;
      out_valid_in = out_valid_ff;
      out_index_in = cnt_ff[smvm_pkg::IdxW-1:0] - row_begin_ff;
      out_sum_in   = b_ctl_ff.nonzero ? sum_sat : '0;
      out_last_in  = is_last;

      if (advance) begin
         out_valid_in = close;
         if (b_ctl_ff.valid) begin
            acc_in = (b_ctl_ff.nonzero && !b_ctl_ff.done) ? sum_sat : '0;
         end
         if (close) begin
            cnt_in = is_last ? {1'b0, row_begin_ff} : cnt_next;
         end
      end

      // Register writes must come only while the pipeline is empty; this block does not enforce it.
      if (csr_write.valid) begin
         case (smvm_pkg::csr_index_type'(csr_write.index))
            smvm_pkg::CSR_ROW_BEGIN: begin
               row_begin_in = csr_write.data[smvm_pkg::IdxW-1:0];
               cnt_in       = {1'b0, csr_write.data[smvm_pkg::IdxW-1:0]};
               acc_in       = '0;
            end
            smvm_pkg::CSR_ROW_END: begin
               row_end_in = csr_write.data;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         cnt_ff       <= '0;
         row_begin_ff <= '0;
         row_end_ff   <= smvm_pkg::RowEndReset;
         out_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         row_begin_ff <= row_begin_in;
         row_end_ff   <= row_end_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_index_ff <= out_index_in;
         out_sum_ff   <= out_sum_in;
         out_last_ff  <= out_last_in;
      end
   end

   assign rsp_word.valid         = out_valid_ff;
   assign rsp_word.index         = out_index_ff;
   assign rsp_word.sum           = out_sum_ff;
   assign rsp_word.last          = out_last_ff;
   assign rsp_word.close_pending = close;

endmodule

[src/sparse_matrix_vector_multiply_unit.sv]
// Sparse matrix vector multiply: top level with input decode and handshakes.
//
// Load words fill the vector memory; nonzero words, in CSR order, then read
// the vector element at their column and are multiplied and summed into a
// saturating Q32.32 accumulator. A row closes on a nonzero marked with tlast
// or on an empty-row word, and one result word carries the row index relative
// to row_begin, the row sum and tlast on the final row of the range. One
// input word is taken per clock cycle while the output is not stalled; a
// closing word passes the memory read, the product register and the result
// register in turn. The whole pipeline holds while a result word waits on
// rsp_tready. Register writes are taken in any cycle but are meant only for
// an idle unit; a write to row_begin also restarts the row count.
`include "sparse_matrix_vector_multiply_unit_defines.svh"

module sparse_matrix_vector_multiply_unit #(
   parameter int MAX_LEN = smvm_pkg::MaxLen
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // index [11:0], value [43:12], zeros [47:44]
   input  logic [1:0]  req_tuser,   // mode [1:0]
   input  logic        req_tlast,   // row_done

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // result_index [11:0], row_sum [75:12], zeros [79:76]
   output logic        rsp_tlast,   // last

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [smvm_pkg::CsrIdxW-1:0] csr_index,
   input  logic [smvm_pkg::CntW-1:0]    csr_data
);

   localparam int AddrW = $clog2(MAX_LEN);

   logic                           advance, accept;
   logic [smvm_pkg::IdxW-1:0]      req_index;
   logic signed [smvm_pkg::ValW-1:0] req_value;
   logic [smvm_pkg::AddrWideW-1:0] idx_wide;
   logic [AddrW-1:0]               addr;
   logic                           in_range, load_en;

   smvm_pkg::stage_ctl_type        a_ctl_ff, a_ctl_in;
   logic signed [smvm_pkg::ValW-1:0] a_value_ff;
   logic [smvm_pkg::ValW-1:0]      rd_data;
   smvm_pkg::csr_write_type        csr_write;
   smvm_pkg::rsp_word_type         rsp_word;

   assign req_index = req_tdata[11:0];
   assign req_value = req_tdata[43:12];
   assign idx_wide  = {{(smvm_pkg::AddrWideW-smvm_pkg::IdxW){1'b0}}, req_index};
   assign addr      = idx_wide[AddrW-1:0];
   assign in_range  = idx_wide < smvm_pkg::AddrWideW'(MAX_LEN);

   // A result word that is not taken stops the whole pipeline.
   assign advance    = !rsp_word.valid || rsp_tready;
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;

   always_comb begin
      a_ctl_in          = '0;
      a_ctl_in.done     = req_tlast;
      a_ctl_in.in_range = in_range;
      load_en           = 1'b0;
      case (smvm_pkg::mode_type'(req_tuser))
         smvm_pkg::MODE_LOAD: begin
            load_en = accept && in_range;
         end
         smvm_pkg::MODE_NONZERO: begin
            a_ctl_in.valid   = accept;
            a_ctl_in.nonzero = 1'b1;
         end
         smvm_pkg::MODE_EMPTY: begin
            a_ctl_in.valid = accept;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctl_ff <= '0;
      end else if (advance) begin
         a_ctl_ff <= a_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_value_ff <= req_value;
      end
   end

   smvm_vec_mem #(
      .DEPTH  (MAX_LEN),
      .ADDR_W (AddrW)
   ) u_vec_mem (
      .clock   (clock),
      .wr_en   (load_en),
      .wr_addr (addr),
      .wr_data (req_value),
      .rd_en   (advance),
      .rd_addr (addr),
      .rd_data (rd_data)
   );

   assign csr_ready       = 1'b1;
   assign csr_write.valid = csr_valid;
   assign csr_write.index = csr_index;
   assign csr_write.data  = csr_data;

   smvm_row_acc u_row_acc (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .a_ctl     (a_ctl_ff),
      .a_value   (a_value_ff),
      .elem      (rd_data),
      .csr_write (csr_write),
      .rsp_word  (rsp_word)
   );

   assign rsp_tvalid = rsp_word.valid;
   assign rsp_tdata  = {4'b0, rsp_word.sum, rsp_word.index};
   assign rsp_tlast  = rsp_word.last;

   `ASSERT_IMPLIES(a_stall_blocks_input, clock, reset,
                   rsp_tvalid && !rsp_tready, !req_tready)
   `ASSERT_NEXT(a_close_gives_result, clock, reset,
                rsp_word.close_pending && advance, rsp_tvalid)
   `ASSERT_NEXT(a_read_holds_in_stall, clock, reset, !advance, $stable(rd_data))

endmodule

[tb/sv/tb_sparse_matrix_vector_multiply_unit.sv]
// Self-checking testbench for the sparse matrix vector multiply unit.
`timescale 1ns / 100ps

module tb_sparse_matrix_vector_multiply_unit;

   localparam int          ItemTarget = 1450;
   localparam int          StallLimit = 3000;
   localparam int          SettleCycles = 10;
   localparam logic [1:0]  ModeUnused = 2'd3;
   localparam logic [31:0] QMax = 32'h7FFF_FFFF;
   localparam logic [31:0] QMin = 32'h8000_0000;
   localparam logic [31:0] QOne = 32'h0001_0000;
   localparam logic [31:0] QMinusOne = 32'hFFFF_0000;
   localparam logic signed [63:0] SumMax = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] SumMin = 64'sh8000_0000_0000_0000;

   typedef struct packed {
      logic [smvm_pkg::IdxW-1:0] index;
      logic [smvm_pkg::SumW-1:0] sum;
      logic                      last;
   } row_result_type;

   // Mirrors the unit's vector memory, accumulator and row counter, and
   // queues the row result that each closing word should produce.
   class smvm_scoreboard;
      logic [smvm_pkg::ValW-1:0]        vec_mem [0:smvm_pkg::MaxLen-1];
      logic signed [smvm_pkg::SumW-1:0] acc;
      logic [smvm_pkg::CntW-1:0]        row_cnt;
      logic [smvm_pkg::IdxW-1:0]        first_row;
      logic [smvm_pkg::CntW-1:0]        end_row;
      row_result_type                   expected_rows[$];
      int unsigned                      error_count;
      int unsigned                      rows_checked;
      int unsigned                      clamp_count;

      function new();
         first_row = '0;
         end_row = smvm_pkg::RowEndReset;
         row_cnt = '0;
         acc = '0;
      endfunction

      function int unsigned pending();
         return expected_rows.size();
      endfunction

      task report_mismatch(string msg);
         error_count++;
         $display("mismatch at %0t: %s", $realtime, msg);
      endtask

      function void note_csr(logic [smvm_pkg::CsrIdxW-1:0] idx,
                             logic [smvm_pkg::CntW-1:0] data);
         case (idx)
            smvm_pkg::CSR_ROW_BEGIN: begin
               first_row = data[smvm_pkg::IdxW-1:0];
               row_cnt = {1'b0, data[smvm_pkg::IdxW-1:0]};
               acc = '0;
            end
            smvm_pkg::CSR_ROW_END: begin
               end_row = data;
            end
            default: ;
         endcase
      endfunction

      function logic signed [smvm_pkg::SumW-1:0] add_clamped(
            logic signed [smvm_pkg::SumW-1:0] a,
            logic signed [smvm_pkg::SumW-1:0] b);
         logic signed [smvm_pkg::SumW:0] wide;
         wide = a + b;
         if (wide[smvm_pkg::SumW] != wide[smvm_pkg::SumW-1]) begin
            clamp_count++;
            return wide[smvm_pkg::SumW] ? SumMin : SumMax;
         end
         return wide[smvm_pkg::SumW-1:0];
      endfunction

      function void close_row(logic signed [smvm_pkg::SumW-1:0] sum);
         logic [smvm_pkg::CntW-1:0] next_cnt;
         logic                      final_row;
         row_result_type            r;
         next_cnt = row_cnt + 13'd1;
         final_row = (next_cnt == end_row);
         r.index = row_cnt[smvm_pkg::IdxW-1:0] - first_row;
         r.sum = sum;
         r.last = final_row;
         expected_rows.push_back(r);
         acc = '0;
         row_cnt = final_row ? {1'b0, first_row} : next_cnt;
      endfunction

      function void note_input(logic [1:0] mode, logic [smvm_pkg::IdxW-1:0] idx,
                               logic [smvm_pkg::ValW-1:0] value, logic done);
         logic signed [smvm_pkg::SumW-1:0] elem;
         logic signed [smvm_pkg::SumW-1:0] factor;
         case (mode)
            smvm_pkg::MODE_LOAD: begin
               vec_mem[idx] = value;
            end
            smvm_pkg::MODE_NONZERO: begin
               elem = $signed(vec_mem[idx]);
               factor = $signed(value);
               acc = add_clamped(acc, elem * factor);
               if (done) close_row(acc);
            end
            smvm_pkg::MODE_EMPTY: begin
               close_row('0);
            end
            default: ;
         endcase
      endfunction

      task check_result(logic [smvm_pkg::IdxW-1:0] idx, logic [smvm_pkg::SumW-1:0] sum,
                        logic last);
         row_result_type r;
         if (expected_rows.size() == 0) begin
            report_mismatch($sformatf("result word with none expected: index %0d sum %h",
                                      idx, sum));
            return;
         end
         r = expected_rows.pop_front();
         if (idx !== r.index)
            report_mismatch($sformatf("row %0d: index %0d, expected %0d",
                                      rows_checked, idx, r.index));
         if (sum !== r.sum)
            report_mismatch($sformatf("row %0d: sum %h, expected %h",
                                      rows_checked, sum, r.sum));
         if (last !== r.last)
            report_mismatch($sformatf("row %0d: last %b, expected %b",
                                      rows_checked, last, r.last));
         rows_checked++;
      endtask
   endclass

   logic                          clock;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [47:0]                   req_tdata = '0;   // index [11:0], value [43:12], zeros [47:44]
   logic [1:0]                    req_tuser = '0;   // mode [1:0]
   logic                          req_tlast = 1'b0; // row_done
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b1;
   logic [79:0]                   rsp_tdata;  // result_index [11:0], row_sum [75:12], zeros [79:76]
   logic                          rsp_tlast;        // last
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [smvm_pkg::CsrIdxW-1:0]  csr_index = smvm_pkg::CSR_ROW_BEGIN;
   logic [smvm_pkg::CntW-1:0]     csr_data = '0;

   smvm_scoreboard                sb = new();
   logic                          written [0:smvm_pkg::MaxLen-1];
   logic [smvm_pkg::IdxW-1:0]     loaded_cols[$];
   int unsigned                   items_sent = 0;
   int unsigned                   csr_writes = 0;
   int unsigned                   phases_run = 0;
   int unsigned                   send_idle_level = 0;

   sparse_matrix_vector_multiply_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Level 0 never idles; higher levels idle more often. Most gaps are short.
   function automatic int unsigned pick_gap(int unsigned level);
      int unsigned r;
      if (level == 0) return 0;
      if ($urandom_range(0, 99) < 100 - 15 * level) return 0;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [smvm_pkg::ValW-1:0] rand_value();
      case ($urandom_range(0, 9))
         0: return QMax;
         1: return QMin;
         2: return '0;
         3, 4, 5: return 32'($urandom_range(0, 32'h1F_FFFF)) - 32'h10_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [smvm_pkg::IdxW-1:0] pick_load_index();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 5) return '0;
      if (r < 10) return '1;
      return 12'($urandom_range(0, smvm_pkg::MaxLen - 1));
   endfunction

   // Columns are drawn only from entries already loaded.
   function automatic logic [smvm_pkg::IdxW-1:0] pick_col();
      return loaded_cols[$urandom_range(0, loaded_cols.size() - 1)];
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance
   // with tvalid still high, so back-to-back words need no extra toggle.
   task automatic send_word(logic [1:0] mode, logic [smvm_pkg::IdxW-1:0] idx,
                            logic [smvm_pkg::ValW-1:0] value, logic done);
      int unsigned gap;
      gap = pick_gap(send_idle_level);
      if (gap != 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = mode;
      req_tdata = {4'b0, value, idx};
      req_tlast = done;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_input(mode, idx, value, done);
      if (mode != ModeUnused) items_sent++;
      @(negedge clock);
   endtask

   task automatic load_word(logic [smvm_pkg::IdxW-1:0] idx, logic [smvm_pkg::ValW-1:0] value,
                            logic done);
      if (!written[idx]) begin
         written[idx] = 1'b1;
         loaded_cols.push_back(idx);
      end
      send_word(smvm_pkg::MODE_LOAD, idx, value, done);
   endtask

   task automatic csr_write(logic [smvm_pkg::CsrIdxW-1:0] idx, logic [smvm_pkg::CntW-1:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.note_csr(idx, data);
      csr_writes++;
      @(negedge clock);
   endtask

   // Holds the sender until every queued row has come back, then lets the
   // pipeline settle so that no word is still in flight.
   task automatic drain_and_settle();
      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic send_row();
      int unsigned nnz;
      int unsigned k;
      logic        cut;
      if ($urandom_range(0, 99) < 12) begin
         send_word(smvm_pkg::MODE_EMPTY, 12'($urandom), $urandom, 1'($urandom));
         return;
      end
      nnz = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      // A few rows are broken off by an empty-row word instead of tlast.
      cut = ($urandom_range(0, 99) < 5);
      for (k = 0; k < nnz; k++) begin
         if ($urandom_range(0, 99) < 3)
            send_word(ModeUnused, 12'($urandom), $urandom, 1'($urandom));
         if ($urandom_range(0, 99) < 4)
            load_word(pick_load_index(), rand_value(), 1'($urandom));
         send_word(smvm_pkg::MODE_NONZERO, pick_col(), rand_value(),
                   !cut && (k == nnz - 1));
      end
      if (cut) send_word(smvm_pkg::MODE_EMPTY, 12'($urandom), $urandom, 1'($urandom));
   endtask

   task automatic run_phase(int unsigned phase);
      logic [smvm_pkg::CntW-1:0] first;
      logic [smvm_pkg::CntW-1:0] past_end;
      int unsigned               target;
      drain_and_settle();
      case (phase)
         0: begin first = 13'd0;    past_end = 13'd1;    end
         1: begin first = 13'd4095; past_end = 13'd4096; end
         2: begin first = 13'h1FFF; past_end = 13'd0;    end
         3: begin first = 13'h1064; past_end = 13'h1FFF; end
         4: begin first = 13'd7;    past_end = 13'd3;    end
         default: begin
            first = 13'($urandom_range(0, smvm_pkg::MaxLen - 1));
            if ($urandom_range(0, 9) == 0) past_end = 13'($urandom);
            else past_end = first + 13'($urandom_range(1, 10));
         end
      endcase
      if ($urandom_range(0, 1) == 0) begin
         csr_write(smvm_pkg::CSR_ROW_BEGIN, first);
         csr_write(smvm_pkg::CSR_ROW_END, past_end);
      end else begin
         csr_write(smvm_pkg::CSR_ROW_END, past_end);
         csr_write(smvm_pkg::CSR_ROW_BEGIN, first);
      end
      csr_valid = 1'b0;
      send_idle_level = $urandom_range(0, 3);
      repeat ($urandom_range(1, 12)) load_word(pick_load_index(), rand_value(), 1'($urandom));
      target = items_sent + $urandom_range(40, 120);
      while (items_sent < target) send_row();
      phases_run++;
   endtask

   initial begin
      int unsigned phase;
      foreach (written[i]) written[i] = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part under the reset configuration.
      load_word(12'd0, QMax, 1'b0);
      load_word(12'd4095, QMin, 1'b1);
      load_word(12'd1, QOne, 1'b0);
      load_word(12'd2, QMinusOne, 1'b0);
      load_word(12'd3, 32'h0, 1'b0);
      // Three products of the most negative values overflow upwards.
      send_word(smvm_pkg::MODE_NONZERO, 12'd4095, QMin, 1'b0);
      send_word(smvm_pkg::MODE_NONZERO, 12'd4095, QMin, 1'b0);
      send_word(smvm_pkg::MODE_NONZERO, 12'd4095, QMin, 1'b1);
      // The opposite pairing clamps at the bottom, then a small term follows.
      send_word(smvm_pkg::MODE_NONZERO, 12'd0, QMin, 1'b0);
      send_word(smvm_pkg::MODE_NONZERO, 12'd0, QMin, 1'b0);
      send_word(smvm_pkg::MODE_NONZERO, 12'd0, QMin, 1'b0);
      send_word(smvm_pkg::MODE_NONZERO, 12'd1, QOne, 1'b1);
      // An empty-row word discards what was summed before it.
      send_word(smvm_pkg::MODE_NONZERO, 12'd1, QMax, 1'b0);
      send_word(smvm_pkg::MODE_EMPTY, 12'd4095, QMin, 1'b1);
      send_word(smvm_pkg::MODE_NONZERO, 12'd2, 32'h0001_2345, 1'b1);
      send_word(ModeUnused, 12'd4095, QMin, 1'b1);
      // A load read back by the very next word.
      load_word(12'd5, 32'hC0DE_1234, 1'b0);
      send_word(smvm_pkg::MODE_NONZERO, 12'd5, QMinusOne, 1'b1);
      send_word(smvm_pkg::MODE_NONZERO, 12'd3, QMax, 1'b1);

      phase = 0;
      while (items_sent < ItemTarget) begin
         run_phase(phase);
         phase++;
      end
      drain_and_settle();

      $display("run covered %0d stream words, %0d row results and %0d register writes",
               items_sent, sb.rows_checked, csr_writes);
      $display("over %0d row ranges, with %0d clamped additions",
               phases_run, sb.clamp_count);
      if (sb.error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // Result side: random stalls of changing density.
   initial begin
      int unsigned stall_left;
      int unsigned stall_level;
      int unsigned cycle;
      stall_left = 0;
      stall_level = 0;
      cycle = 0;
      forever begin
         @(negedge clock);
         cycle++;
         if (cycle % 200 == 0) stall_level = $urandom_range(0, 3);
         if (stall_left > 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else begin
            stall_left = pick_gap(stall_level);
            if (stall_left > 0) begin
               rsp_tready = 1'b0;
               stall_left--;
            end else begin
               rsp_tready = 1'b1;
            end
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata[11:0], rsp_tdata[75:12], rsp_tlast);
      end
   end

   // Ends the run if no word moves on any channel for too long.
   initial begin
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < StallLimit) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
             || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("timeout: no word accepted for %0d cycles", StallLimit);
      $display("tb: failure");
      $finish;
   end

endmodule

[filelist.f]
+incdir+src
src/smvm_pkg.sv
src/smvm_vec_mem.sv
src/smvm_row_acc.sv
src/sparse_matrix_vector_multiply_unit.sv
tb/sv/tb_sparse_matrix_vector_multiply_unit.sv
